>>> design/arot_pkg.sv
// shared types and constants for the address range overlay table
// no dependencies; imported by arot_cell and address_range_overlay_table_unit
package arot_pkg;

	localparam int SLOTS   = 64;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = IDX_W + 2;
	localparam int MAP_W   = 10;
	localparam int ADDR_W  = 64;
	localparam int SPACE_W = 16;
	localparam int TAG_W   = 10;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_INSERT,
		KIND_LOOKUP,
		KIND_NEXT
	} kind_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		kind_t              kind;
		logic [SPACE_W-1:0] space;
		logic [ADDR_W-1:0]  address;
		logic [ADDR_W-1:0]  length;
		logic [TAG_W-1:0]   mapping_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [TAG_W-1:0]  hit_mapping;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] range_first;
		logic [ADDR_W-1:0] range_limit;
	} rsp_t;

	typedef struct packed {
		logic [SPACE_W-1:0] space;
		logic [ADDR_W-1:0]  start;
		logic [ADDR_W-1:0]  limit;
		logic [MAP_W-1:0]   mapping;
		logic [ADDR_W-1:0]  origin;
	} slot_pay_t;

	typedef struct packed {
		logic      valid;
		slot_pay_t pay;
	} slot_t;

	typedef struct packed {
		logic shift;
		logic clr;
	} slot_ctl_t;

endpackage

>>> design/arot_cell.sv
// one slot of the rotating range ring
// depends on arot_pkg
module arot_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  arot_pkg::slot_ctl_t ctl,
	input  arot_pkg::slot_t     d,
	output arot_pkg::slot_t     q
);
	import arot_pkg::*;

	logic      valid_q;
	slot_pay_t pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			pay_q <= d.pay;
		end
	end

	assign q = '{valid: valid_q, pay: pay_q};

endmodule

>>> design/address_range_overlay_table_unit.sv
// address range overlay table: ring of slot cells rotating past one head stage
// depends on arot_pkg and arot_cell
//
//   port group   dir   handshake            beat
//   req          in    req_valid/req_stall  req_t: kind, space, address, length, tag
//   rsp          out   rsp_valid/rsp_stall  rsp_t: status, mapping, offset, range
//
// clear and zero-size insert answer without a ring pass; lookup and next-range take a find pass and a resolve step;
// insert takes a count pass on a full table, else count, edit and place passes, one ring rotation a pass.
// the ring of slots rotates one place per cycle past the head logic while a pass runs, and holds still otherwise.
// reset empties the table at once; no clearing pass.
// one request at a time; a new request is taken while the last beat waits on rsp_stall.
module address_range_overlay_table_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  arot_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output arot_pkg::rsp_t rsp
);
	import arot_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_EDIT,
		S_PLACE,
		S_FIND,
		S_RESOLVE,
		S_EMIT
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [ADDR_W-1:0]  e_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   used_q, removed_q, splits_q;
	logic               found_q, have_right_q, new_pend_q;
	slot_pay_t          best_q;
	slot_t              right_q;
	rsp_t               res_q, rsp_q;
	logic               rsp_valid_q;

	slot_t              slot_w [SLOTS];
	logic [SLOTS-1:0]   vld_w;
	slot_t              head, hn, new_w;
	slot_ctl_t          ctl;

	logic               req_fire, out_free, last;
	logic [ADDR_W:0]    sum_w;
	logic [ADDR_W-1:0]  sat_w;
	logic               ov, split, covered;
	logic [CNT_W-1:0]   used_n, removed_n, splits_n;
	logic               full_w, look_hit, next_hit, lk_ok;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign last      = (cnt_q == IDX_W'(SLOTS - 1));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ctl.shift = (state_q == S_COUNT) || (state_q == S_EDIT) ||
	                   (state_q == S_PLACE) || (state_q == S_FIND);
	assign ctl.clr   = req_fire && (req.kind == KIND_CLEAR);

	for (genvar i = 0; i < SLOTS; i++) begin : g_ring
		slot_t d_w;
		if (i == SLOTS - 1) begin : g_tail
			assign d_w = hn;
		end else begin : g_mid
			assign d_w = slot_w[i+1];
		end
		arot_cell u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (d_w),
			.q      (slot_w[i])
		);
		assign vld_w[i] = slot_w[i].valid;
	end

	assign head = slot_w[0];

	// saturating end of base + size
	assign sum_w = {1'b0, req.address} + {1'b0, req.length};
	assign sat_w = sum_w[ADDR_W] ? '1 : sum_w[ADDR_W-1:0];

	assign new_w = '{valid: 1'b1,
	                 pay: '{space: req_q.space, start: req_q.address, limit: e_q,
	                        mapping: req_q.mapping_tag[MAP_W-1:0],
	                        origin: req_q.address}};

	assign ov      = head.valid && (head.pay.space == req_q.space) &&
	                 (head.pay.limit > req_q.address) && (head.pay.start < e_q);
	assign split   = ov && (head.pay.start < req_q.address) && (head.pay.limit > e_q);
	assign covered = ov && (head.pay.start >= req_q.address) && (head.pay.limit <= e_q);

	assign used_n    = used_q + CNT_W'(head.valid);
	assign removed_n = removed_q + CNT_W'(covered);
	assign splits_n  = splits_q + CNT_W'(split);
	assign full_w    = (used_n + splits_n + CNT_W'(1)) > (CNT_W'(SLOTS) + removed_n);

	assign look_hit = !found_q && (req_q.length != '0) && head.valid &&
	                  (head.pay.space == req_q.space) &&
	                  (head.pay.start <= req_q.address) && (req_q.address < head.pay.limit);
	assign next_hit = head.valid && (head.pay.space == req_q.space) &&
	                  (head.pay.start >= req_q.address) &&
	                  (!found_q || (head.pay.start < best_q.start));
	assign lk_ok    = found_q && (e_q > req_q.address) && (e_q <= best_q.limit);

	// head edits written back into the tail of the ring
	always_comb begin
		hn = head;
		unique case (state_q)
			S_EDIT: begin
				if (ov) begin
					priority if (split) begin
						hn.pay.limit = req_q.address;
					end else if (head.pay.start < req_q.address) begin
						hn.pay.limit = req_q.address;
					end else if (head.pay.limit > e_q) begin
						hn.pay.start = e_q;
					end else begin
						hn.valid = 1'b0;
					end
				end
			end
			S_PLACE: begin
				if (!head.valid) begin
					if (have_right_q) begin
						hn = right_q;
					end else if (new_pend_q) begin
						hn = new_w;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			e_q          <= '0;
			cnt_q        <= '0;
			used_q       <= '0;
			removed_q    <= '0;
			splits_q     <= '0;
			found_q      <= 1'b0;
			have_right_q <= 1'b0;
			new_pend_q   <= 1'b0;
			best_q       <= '0;
			right_q      <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						req_q        <= req;
						e_q          <= sat_w;
						cnt_q        <= '0;
						used_q       <= '0;
						removed_q    <= '0;
						splits_q     <= '0;
						found_q      <= 1'b0;
						have_right_q <= 1'b0;
						new_pend_q   <= 1'b1;
						res_q        <= '0;
						unique case (req.kind)
							KIND_CLEAR: state_q <= S_EMIT;
							KIND_INSERT: begin
								if (req.length == '0 || sat_w <= req.address) begin
									state_q <= S_EMIT;
								end else begin
									state_q <= S_COUNT;
								end
							end
							KIND_LOOKUP, KIND_NEXT: state_q <= S_FIND;
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_COUNT: begin
					cnt_q     <= cnt_q + 1'b1;
					used_q    <= used_n;
					removed_q <= removed_n;
					splits_q  <= splits_n;
					if (last) begin
						if (full_w) begin
							res_q.status <= ST_FULL;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_EDIT;
						end
					end
				end
				S_EDIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (split) begin
						have_right_q <= 1'b1;
						right_q      <= '{valid: 1'b1,
						                  pay: '{space: req_q.space, start: e_q,
						                         limit: head.pay.limit,
						                         mapping: head.pay.mapping,
						                         origin: head.pay.origin}};
					end
					if (last) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					cnt_q <= cnt_q + 1'b1;
					if (!head.valid) begin
						if (have_right_q) begin
							have_right_q <= 1'b0;
						end else begin
							new_pend_q <= 1'b0;
						end
					end
					if (last) begin
						state_q <= S_EMIT;
					end
				end
				S_FIND: begin
					cnt_q <= cnt_q + 1'b1;
					if ((req_q.kind == KIND_LOOKUP) ? look_hit : next_hit) begin
						found_q <= 1'b1;
						best_q  <= head.pay;
					end
					if (last) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if ((req_q.kind == KIND_LOOKUP) ? lk_ok : found_q) begin
						res_q.status      <= ST_OK;
						res_q.hit_mapping <= TAG_W'(best_q.mapping);
						res_q.offset      <= (req_q.kind == KIND_LOOKUP) ?
						                     (req_q.address - best_q.origin) : '0;
						res_q.range_first <= best_q.start;
						res_q.range_limit <= best_q.limit;
					end else begin
						res_q.status <= ST_MISS;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.kind == KIND_CLEAR) |=> (vld_w == '0))
		else $error("table not empty after clear");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_MISS ||
		               rsp.status == ST_FULL))
		else $error("bad status code");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> req_stall)
		else $error("request taken while busy");

	// the count pass ends one full rotation after it began
	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COUNT && last && full_w) |=> (vld_w == $past(vld_w, SLOTS)))
		else $error("full insert changed the table");

endmodule
